/* design/clns_pkg.sv */
// Shared types, command codes, LCD instruction constants and helper functions
// for the character LCD nibble sequencer. No dependencies.

package clns_pkg;

  // Field widths
  localparam int CMD_W      = 3;
  localparam int CODE_W     = 8;
  localparam int COL_W      = 6;
  localparam int SLOT_W     = 3;
  localparam int ROWS_W     = 64;
  localparam int NIB_W      = 4;
  localparam int LINE_LEN_W = 6;
  localparam int NCNT_W     = 5;   // nibble counter, up to 20 nibbles per job

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PRINT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SETPOS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HOME   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SHIFT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_GLYPH  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RAW_IR = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RAW_DR = 3'd7;

  // Register select
  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  // LCD instructions
  localparam logic [7:0] LCD_SET_CGRAM = 8'h40;
  localparam logic [7:0] LCD_SHIFT     = 8'h10;
  localparam logic [7:0] LCD_HOME      = 8'h02;
  localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [NIB_W-1:0] LCD_WAKE_NIB  = 4'h3;
  localparam logic [NIB_W-1:0] LCD_4BIT_NIB  = 4'h2;

  localparam logic [LINE_LEN_W-1:0] LINE_LEN_RESET = 6'd16;
  localparam int QUEUE_DEPTH = 2;

  // Job kinds handed from the front end to the nibble emitter
  localparam logic [1:0] JOB_INIT      = 2'd0;
  localparam logic [1:0] JOB_BYTE      = 2'd1;
  localparam logic [1:0] JOB_BYTE_ADDR = 2'd2;
  localparam logic [1:0] JOB_GLYPH     = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic              rs;     // register select of the first byte
    logic [7:0]        byte0;  // first byte of the job
    logic [ROWS_W-1:0] rows;   // glyph row bytes, first row in MSB
    logic [7:0]        addr;   // trailing set-DDRAM-address byte
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic valid;   // queue not empty
    job_t head;
  } q_stat_t;

  // Set-DDRAM-address instruction: 0x80 | row<<6 | col
  function automatic logic [7:0] ddram_addr(input logic row, input logic [COL_W-1:0] col);
    ddram_addr = {1'b1, row, col};
  endfunction

  // Index of the final nibble of a job
  function automatic logic [NCNT_W-1:0] job_last_idx(input logic [1:0] kind);
    case (kind)
      JOB_INIT:      job_last_idx = 5'd13;
      JOB_BYTE:      job_last_idx = 5'd1;
      JOB_BYTE_ADDR: job_last_idx = 5'd3;
      JOB_GLYPH:     job_last_idx = 5'd19;
      default:       job_last_idx = 5'd1;
    endcase
  endfunction

  // Power-up sequence: three wake nibbles, the 4-bit switch, then five bytes
  function automatic logic [NIB_W-1:0] init_nibble(input logic [3:0] idx);
    logic [7:0] b;
    case (idx[3:1])
      3'd2:    b = LCD_FUNC_SET;
      3'd3:    b = LCD_CLEAR;
      3'd4:    b = LCD_HOME;
      3'd5:    b = LCD_DISP_ON;
      default: b = LCD_ENTRY;
    endcase
    if (idx < 4'd3) begin
      init_nibble = LCD_WAKE_NIB;
    end else if (idx == 4'd3) begin
      init_nibble = LCD_4BIT_NIB;
    end else if (idx[0]) begin
      init_nibble = b[3:0];
    end else begin
      init_nibble = b[7:4];
    end
  endfunction

endpackage

/* design/clns_if.sv */
// Channel interfaces of the LCD nibble sequencer: command input, nibble
// output and line-length configuration. Depends on clns_pkg.

interface clns_in_if;
  logic                            valid;
  logic                            ready;
  logic [clns_pkg::CMD_W-1:0]      cmd;
  logic [clns_pkg::CODE_W-1:0]     char_code;
  logic                            row;
  logic [clns_pkg::COL_W-1:0]      col;
  logic                            shift_target;
  logic                            shift_dir;
  logic [clns_pkg::SLOT_W-1:0]     glyph_slot;
  logic [clns_pkg::ROWS_W-1:0]     glyph_rows;

  modport source (output valid, cmd, char_code, row, col, shift_target, shift_dir,
                  glyph_slot, glyph_rows, input ready);
  modport sink (input valid, cmd, char_code, row, col, shift_target, shift_dir,
                glyph_slot, glyph_rows, output ready);
endinterface

interface clns_out_if;
  logic                        valid;
  logic                        ready;
  logic                        reg_select;
  logic [clns_pkg::NIB_W-1:0]  nibble;
  logic                        last;

  modport source (output valid, reg_select, nibble, last, input ready);
  modport sink (input valid, reg_select, nibble, last, output ready);
endinterface

interface clns_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [clns_pkg::LINE_LEN_W-1:0]  line_length;

  modport source (output valid, line_length, input ready);
  modport sink (input valid, line_length, output ready);
endinterface

/* design/clns_front.sv */
// Front end: accepts commands, tracks the cursor and line length, and turns
// each command into a job for the nibble emitter. Depends on clns_pkg, clns_if.

module clns_front (
  input  logic                clk,
  input  logic                rst_n,
  clns_in_if.sink             in_ch,
  clns_cfg_if.sink            cfg_ch,
  input  clns_pkg::q_stat_t   q_stat,
  output clns_pkg::q_push_t   q_push
);

  localparam logic [2:0] DIV_LAST = 3'd6;   // 7 remainder steps

  logic [clns_pkg::LINE_LEN_W-1:0] line_len_r, line_len_nxt;
  logic                            row_r, row_nxt;
  logic [clns_pkg::COL_W-1:0]      col_r, col_nxt;
  logic                            busy_r, busy_nxt;
  logic [2:0]                      div_cnt_r, div_cnt_nxt;
  logic [5:0]                      div_rem_r, div_rem_nxt;
  logic [6:0]                      div_num_r, div_num_nxt;
  logic [clns_pkg::CODE_W-1:0]     code_r, code_nxt;

  logic       accept;
  logic [6:0] len7, next7, diff7, shifted7;
  logic [5:0] rem_step;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_stat.full && !busy_r;
  assign accept       = in_ch.valid && in_ch.ready;

  // Column arithmetic: zero line length means 64
  assign len7  = (line_len_r == '0) ? 7'd64 : {1'b0, line_len_r};
  assign next7 = {1'b0, col_r} + 7'd1;
  assign diff7 = next7 - len7;

  // One restoring remainder step
  assign shifted7 = {div_rem_r, div_num_r[6]};
  always_comb begin
    if (shifted7 >= len7) begin
      rem_step = 6'(shifted7 - len7);
    end else begin
      rem_step = shifted7[5:0];
    end
  end

  // Command decode and cursor tracking
  always_comb begin
    line_len_nxt = line_len_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    busy_nxt     = busy_r;
    div_cnt_nxt  = div_cnt_r;
    div_rem_nxt  = div_rem_r;
    div_num_nxt  = div_num_r;
    code_nxt     = code_r;

    q_push.valid     = 1'b0;
    q_push.job.kind  = clns_pkg::JOB_BYTE;
    q_push.job.rs    = clns_pkg::RS_INSTR;
    q_push.job.byte0 = in_ch.char_code;
    q_push.job.rows  = in_ch.glyph_rows;
    q_push.job.addr  = clns_pkg::ddram_addr(row_r, col_r);

    if (cfg_ch.valid && cfg_ch.ready) begin
      line_len_nxt = cfg_ch.line_length;
    end

    if (busy_r) begin
      // wrap needing a full remainder
      div_rem_nxt = rem_step;
      div_num_nxt = {div_num_r[5:0], 1'b0};
      div_cnt_nxt = div_cnt_r + 3'd1;
      if (div_cnt_r == DIV_LAST) begin
        busy_nxt         = 1'b0;
        col_nxt          = rem_step;
        q_push.valid     = 1'b1;
        q_push.job.kind  = clns_pkg::JOB_BYTE_ADDR;
        q_push.job.rs    = clns_pkg::RS_DATA;
        q_push.job.byte0 = code_r;
        q_push.job.addr  = clns_pkg::ddram_addr(row_r, rem_step);
      end
    end else if (accept) begin
      case (in_ch.cmd)
        clns_pkg::CMD_INIT: begin
          row_nxt         = 1'b0;
          col_nxt         = '0;
          q_push.valid    = 1'b1;
          q_push.job.kind = clns_pkg::JOB_INIT;
        end
        clns_pkg::CMD_PRINT: begin
          q_push.job.rs = clns_pkg::RS_DATA;
          if (next7 < len7) begin
            col_nxt      = next7[5:0];
            q_push.valid = 1'b1;
          end else if (diff7 < len7) begin
            col_nxt         = diff7[5:0];
            q_push.valid    = 1'b1;
            q_push.job.kind = clns_pkg::JOB_BYTE_ADDR;
            q_push.job.addr = clns_pkg::ddram_addr(row_r, diff7[5:0]);
          end else begin
            busy_nxt    = 1'b1;
            div_cnt_nxt = '0;
            div_rem_nxt = '0;
            div_num_nxt = next7;
            code_nxt    = in_ch.char_code;
          end
        end
        clns_pkg::CMD_SETPOS: begin
          row_nxt          = in_ch.row;
          col_nxt          = in_ch.col;
          q_push.valid     = 1'b1;
          q_push.job.byte0 = clns_pkg::ddram_addr(in_ch.row, in_ch.col);
        end
        clns_pkg::CMD_HOME: begin
          row_nxt          = 1'b0;
          col_nxt          = '0;
          q_push.valid     = 1'b1;
          q_push.job.byte0 = clns_pkg::LCD_HOME;
        end
        clns_pkg::CMD_SHIFT: begin
          q_push.valid     = 1'b1;
          q_push.job.byte0 = clns_pkg::LCD_SHIFT |
                             {4'b0, in_ch.shift_target, in_ch.shift_dir, 2'b0};
        end
        clns_pkg::CMD_GLYPH: begin
          q_push.valid     = 1'b1;
          q_push.job.kind  = clns_pkg::JOB_GLYPH;
          q_push.job.byte0 = clns_pkg::LCD_SET_CGRAM | {2'b0, in_ch.glyph_slot, 3'b0};
        end
        clns_pkg::CMD_RAW_IR: begin
          q_push.valid = 1'b1;
        end
        default: begin
          q_push.valid  = 1'b1;
          q_push.job.rs = clns_pkg::RS_DATA;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= clns_pkg::LINE_LEN_RESET;
      row_r      <= 1'b0;
      col_r      <= '0;
      busy_r     <= 1'b0;
    end else begin
      line_len_r <= line_len_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      busy_r     <= busy_nxt;
    end
  end

  // Remainder unit datapath
  always_ff @(posedge clk) begin
    div_cnt_r <= div_cnt_nxt;
    div_rem_r <= div_rem_nxt;
    div_num_r <= div_num_nxt;
    code_r    <= code_nxt;
  end

endmodule

/* design/clns_queue.sv */
// Small job queue between the front end and the nibble emitter.
// Depends on clns_pkg.

module clns_queue #(
  parameter int DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  clns_pkg::q_push_t   q_push,
  input  logic                pop,
  output clns_pkg::q_stat_t   q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  clns_pkg::job_t entries_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = q_push.valid && (count_r != CNT_W'(DEPTH));
  assign do_pop  = pop && (count_r != '0);

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.valid = (count_r != '0);
  assign q_stat.head  = entries_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= q_push.job;
    end
  end

endmodule

/* design/clns_back.sv */
// Back end: walks the job at the head of the queue one nibble per cycle (while
// out_ch.ready does not stall) into a registered output stage. Depends on clns_pkg, clns_if.

module clns_back (
  input  logic                clk,
  input  logic                rst_n,
  input  clns_pkg::q_stat_t   q_stat,
  output logic                pop,
  clns_out_if.source          out_ch
);

  logic [clns_pkg::NCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        rs_r;
  logic [clns_pkg::NIB_W-1:0]  nib_r;
  logic                        last_r;

  clns_pkg::job_t   job;
  logic             load, emit, is_last;
  logic [3:0]       byte_idx;
  logic [2:0]       row_idx;
  logic [7:0]       cur_byte;
  logic             cur_rs;
  logic [clns_pkg::NIB_W-1:0] cur_nib;

  assign job      = q_stat.head;
  assign load     = !out_valid_r || out_ch.ready;
  assign emit     = load && q_stat.valid;
  assign is_last  = (cnt_r == clns_pkg::job_last_idx(job.kind));
  assign pop      = emit && is_last;
  assign byte_idx = cnt_r[4:1];
  assign row_idx  = 3'(byte_idx - 4'd1);

  // Byte and register select for the current nibble
  always_comb begin
    if (byte_idx == 4'd0) begin
      cur_byte = job.byte0;
      cur_rs   = job.rs;
    end else if ((job.kind == clns_pkg::JOB_BYTE_ADDR && byte_idx == 4'd1) ||
                 (job.kind == clns_pkg::JOB_GLYPH && byte_idx == 4'd9)) begin
      cur_byte = job.addr;
      cur_rs   = clns_pkg::RS_INSTR;
    end else begin
      cur_byte = job.rows[{~row_idx, 3'b000} +: 8];
      cur_rs   = clns_pkg::RS_DATA;
    end
  end

  // High nibble first; the init job has its own sequence
  always_comb begin
    if (job.kind == clns_pkg::JOB_INIT) begin
      cur_nib = clns_pkg::init_nibble(cnt_r[3:0]);
    end else if (!cnt_r[0]) begin
      cur_nib = cur_byte[7:4];
    end else begin
      cur_nib = cur_byte[3:0];
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = q_stat.valid;
    end
    if (emit) begin
      cnt_nxt = is_last ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      rs_r   <= (job.kind == clns_pkg::JOB_INIT) ? clns_pkg::RS_INSTR : cur_rs;
      nib_r  <= cur_nib;
      last_r <= is_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.reg_select = rs_r;
  assign out_ch.nibble     = nib_r;
  assign out_ch.last       = last_r;

endmodule

/* design/char_lcd_nibble_sequencer.sv */
// Top level of the character LCD nibble sequencer: front end, job queue and
// nibble emitter. Depends on clns_pkg, clns_if and the clns_* modules.
//
// Turns LCD commands into 4-bit bus writes, one nibble per output transaction,
// each tagged with register select and a last flag on the final nibble of the
// command. The output delivers one nibble per cycle unless out_ch.ready stalls
// it; a command is 2 (single byte), 4 (print with wrap), 14 (init) or 20 (glyph)
// nibbles long. The front end accepts a new command in the cycle after the
// previous one while the job queue (QUEUE_DEPTH entries) has room. A print whose
// wrap needs more than one subtraction of the line length (column placed well
// past the line end) goes through the front-end remainder unit before the next
// command is taken. line_length 0 counts as 64. No delays, enable strobes or
// busy-flag polling are generated.

module char_lcd_nibble_sequencer #(
  parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  clns_cfg_if.sink   cfg_ch,
  clns_in_if.sink    in_ch,
  clns_out_if.source out_ch
);

  clns_pkg::q_push_t q_push;
  clns_pkg::q_stat_t q_stat;
  logic              pop;

  clns_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_stat (q_stat),
    .q_push (q_push)
  );

  clns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat)
  );

  clns_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
